>>> rtl/sm4_pkg.sv
// Shared types, constants and functions of the SM4 CBC block cipher.
package sm4_pkg;

  localparam int Rounds = 32;
  localparam int RndW = $clog2(Rounds);
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIvHigh = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIvLow = 3'd3;
  localparam logic [CfgIdxW-1:0] RegChainEn = 3'd4;

  localparam logic [31:0] Fk0 = 32'ha3b1bac6;
  localparam logic [31:0] Fk1 = 32'h56aa3350;
  localparam logic [31:0] Fk2 = 32'h677d9197;
  localparam logic [31:0] Fk3 = 32'hb27022dc;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        chain_start;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_req_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic            load_key;  // load FK-whitened key into the shift register
    logic            key_step;  // one key schedule round
    logic            load_blk;  // load input block (with chain xor)
    logic            rnd_step;  // one cipher round
    logic            finish;    // form result, update chain
    logic [RndW-1:0] rnd;       // round counter
  } sm4_cmd_t;

  localparam logic [7:0] Sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] v);
    tau = {Sbox[v[31:24]], Sbox[v[23:16]], Sbox[v[15:8]], Sbox[v[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] t_round(input logic [31:0] v);
    logic [31:0] b;
    b = tau(v);
    t_round = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] t_key(input logic [31:0] v);
    logic [31:0] b;
    b = tau(v);
    t_key = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK word i: byte j is (4*i + j) * 7 mod 256, most significant first.
  function automatic logic [31:0] ck_word(input logic [RndW-1:0] i);
    logic [7:0] base;
    base = {i, 2'b00} * 8'd7;
    ck_word = {base, base + 8'd7, base + 8'd14, base + 8'd21};
  endfunction

endpackage

>>> rtl/sm4_ram.sv
// Generic single-port RAM with registered read.
module sm4_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

>>> rtl/sm4_ctrl.sv
// Sequencer for key expansion and the 32 cipher rounds.
module sm4_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_busy,   // result register still holds a request
  input  logic             keys_ready,
  output sm4_pkg::sm4_cmd_t cmd
);
  import sm4_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_KLOAD, S_KEXP, S_BLOAD, S_ROUND, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    cmd = '0;
    cmd.rnd = rnd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = keys_ready ? S_BLOAD : S_KLOAD;
        end
      end
      S_KLOAD: begin
        cmd.load_key = 1'b1;
        rnd_nxt = '0;
        state_nxt = S_KEXP;
      end
      S_KEXP: begin
        cmd.key_step = 1'b1;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RndW'(Rounds - 1)) begin
          state_nxt = S_BLOAD;
        end
      end
      S_BLOAD: begin
        // Address for round 0 is presented here; the RAM answers next cycle.
        cmd.load_blk = 1'b1;
        rnd_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.rnd_step = 1'b1;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RndW'(Rounds - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
    end
  end

endmodule

>>> rtl/sm4_dp.sv
// Datapath: key schedule, round function, chaining and configuration registers.
module sm4_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sm4_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sm4_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                             in_accept,
  input  sm4_pkg::in_req_t                 in_req,
  input  sm4_pkg::sm4_cmd_t                cmd,
  output logic                             keys_ready,
  input  logic                             out_ready,
  output logic                             out_valid,
  output sm4_pkg::out_req_t                out_req
);
  import sm4_pkg::*;

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        chain_en_r, keys_ready_r;
  logic [63:0] chain_high_r, chain_low_r;
  in_req_t     req_r;
  logic [31:0] k_r [4];
  logic [31:0] x_r [4];
  logic [31:0] rk_nxt, x_nxt, rk_rd;
  logic [RndW-1:0] ram_addr;
  logic [127:0] pre, res;
  logic        out_valid_r;
  out_req_t    out_r;

  assign keys_ready = keys_ready_r;
  assign out_valid = out_valid_r;
  assign out_req = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
      iv_high_r <= '0;
      iv_low_r <= '0;
      chain_en_r <= 1'b1;
      keys_ready_r <= 1'b0;
      chain_high_r <= '0;
      chain_low_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegKeyHigh: begin key_high_r <= cfg_data; keys_ready_r <= 1'b0; end
          RegKeyLow:  begin key_low_r <= cfg_data; keys_ready_r <= 1'b0; end
          RegIvHigh:  iv_high_r <= cfg_data;
          RegIvLow:   iv_low_r <= cfg_data;
          RegChainEn: chain_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.key_step && cmd.rnd == RndW'(Rounds - 1)) begin
        keys_ready_r <= 1'b1;
      end
      if (cmd.finish && chain_en_r) begin
        {chain_high_r, chain_low_r} <= req_r.kind ? {req_r.block_high, req_r.block_low}
                                                  : res;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Key schedule round and cipher round.
  assign rk_nxt = k_r[0] ^ t_key(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(cmd.rnd));
  assign x_nxt = x_r[0] ^ t_round(x_r[1] ^ x_r[2] ^ x_r[3] ^ rk_rd);

  // During rounds the read address fetches the key of the next round.
  always_comb begin
    if (cmd.key_step) begin
      ram_addr = cmd.rnd;
    end else if (cmd.load_blk) begin
      ram_addr = req_r.kind ? RndW'(Rounds - 1) : '0;
    end else begin
      ram_addr = req_r.kind ? RndW'(Rounds - 2) - cmd.rnd : cmd.rnd + 1'b1;
    end
  end

  sm4_ram #(.Width(32), .Depth(Rounds)) u_rk_ram (
    .clk  (clk),
    .we   (cmd.key_step),
    .addr (ram_addr),
    .wdata(rk_nxt),
    .rdata(rk_rd)
  );

  always_comb begin
    pre = {req_r.block_high, req_r.block_low};
    if (chain_en_r && !req_r.kind) begin
      pre = pre ^ (req_r.chain_start ? {iv_high_r, iv_low_r} : {chain_high_r, chain_low_r});
    end
    res = {x_r[3], x_r[2], x_r[1], x_r[0]};
    if (chain_en_r && req_r.kind) begin
      res = res ^ (req_r.chain_start ? {iv_high_r, iv_low_r} : {chain_high_r, chain_low_r});
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_req;
    end
    if (cmd.load_key) begin
      k_r[0] <= key_high_r[63:32] ^ Fk0;
      k_r[1] <= key_high_r[31:0] ^ Fk1;
      k_r[2] <= key_low_r[63:32] ^ Fk2;
      k_r[3] <= key_low_r[31:0] ^ Fk3;
    end else if (cmd.key_step) begin
      k_r[0] <= k_r[1];
      k_r[1] <= k_r[2];
      k_r[2] <= k_r[3];
      k_r[3] <= rk_nxt;
    end
    if (cmd.load_blk) begin
      x_r[0] <= pre[127:96];
      x_r[1] <= pre[95:64];
      x_r[2] <= pre[63:32];
      x_r[3] <= pre[31:0];
    end else if (cmd.rnd_step) begin
      x_r[0] <= x_r[1];
      x_r[1] <= x_r[2];
      x_r[2] <= x_r[3];
      x_r[3] <= x_nxt;
    end
    if (cmd.finish) begin
      out_r <= '{result_high: res[127:64], result_low: res[63:0]};
    end
  end

endmodule

>>> rtl/sm4_cbc_block_cipher.sv
// Top level of the SM4 block cipher with optional CBC chaining.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_req_t: kind, block, chain_start
//   out_     output     out_valid/out_ready out_req_t: result block
//   cfg_     input      cfg_we             cfg_index, cfg_data (64 bits)
//
// After a request is accepted in the idle state, the core loads the block, runs
// the 32 rounds (one round per cycle through the shared round function and the
// round key RAM), and forms the result.
// The first request after reset or after a key write is preceded by key
// expansion: the FK-whitened key is loaded, then one key schedule round per
// cycle is written into the RAM.
// Reset is synchronous and active low; it clears control state, key, IV and
// chain value, and enables chaining. The result register holds a request until
// out_ready; a new request is taken once the previous result is in the result
// register, so it can overlap with that result waiting at the output.
module sm4_cbc_block_cipher (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sm4_pkg::in_req_t             in_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sm4_pkg::out_req_t            out_req,
  input  logic                         cfg_we,
  input  logic [sm4_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sm4_pkg::CfgDataW-1:0] cfg_data
);
  import sm4_pkg::*;

  sm4_cmd_t cmd;
  logic     keys_ready;
  logic     out_busy;

  // The finish step waits while the output register still holds an untaken result.
  assign out_busy = out_valid && !out_ready;

  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_busy  (out_busy),
    .keys_ready(keys_ready),
    .cmd       (cmd)
  );

  sm4_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_valid && in_ready),
    .in_req    (in_req),
    .cmd       (cmd),
    .keys_ready(keys_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_req   (out_req)
  );

endmodule
